// File: hw/rtl/pgi_pkg.sv
// Shared types, constants and helpers of the particle gravity integrator.
package pgi_pkg;

    // Sizes
    localparam int MAX_P     = 32;
    localparam int NFRAMES   = 3;
    localparam int IDX_W     = $clog2(MAX_P);
    localparam int CNT_W     = $clog2(MAX_P + 1);
    localparam int POS_DEPTH = NFRAMES * MAX_P;
    localparam int ADDR_W    = $clog2(POS_DEPTH);
    localparam int PROD_W    = 49;   // 32 x 17 signed product
    localparam int SUM_W     = 51;   // position + product + bias, before saturation
    localparam int LIFE_W    = 18;

    localparam logic [15:0] LIFETIME_RST = 16'd60;

    // Request opcodes
    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_TICK = 2'd1;
    localparam logic [1:0] OP_ARM  = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_POS     = 2'd0;
    localparam logic [1:0] ST_EXPIRED = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_GRAVITY  = 2'd0;
    localparam logic [1:0] CFG_ACTIVE   = 2'd1;
    localparam logic [1:0] CFG_LIFETIME = 2'd2;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [4:0]         particle_index;
        logic signed [31:0] load_x;
        logic signed [31:0] load_y;
        logic signed [31:0] load_z;
        logic signed [31:0] load_vx;
        logic signed [31:0] load_vy;
        logic signed [31:0] load_vz;
        logic [7:0]         step_ticks;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic [4:0]         out_index;
        logic signed [31:0] new_x;
        logic signed [31:0] new_y;
        logic signed [31:0] new_z;
        logic [1:0]         frame_phase;
        logic [1:0]         bank_level;
        logic [1:0]         bank_cursor;
        logic               last;
    } t_res;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_TRI,
        S_GS,
        S_BIAS,
        S_RD,
        S_MX,
        S_MY,
        S_MZ,
        S_WR
    } t_state;

    // Operand selection of the shared multiplier
    typedef enum logic [1:0] {
        MUL_TRI,   // s * (s + 1)
        MUL_GS,    // gravity * s
        MUL_BIAS,  // gravity * s(s+1)/2
        MUL_VEL    // velocity * s
    } t_mul_sel;

    typedef struct packed {
        t_mul_sel           sel;
        logic signed [31:0] vel;
        logic [7:0]         step;
        logic [15:0]        tri_num;
    } t_mul_ctl;

    // Clamp a wide signed sum to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [31:0] res;
        if (v[SUM_W-1:31] == {(SUM_W-31){1'b0}} || v[SUM_W-1:31] == {(SUM_W-31){1'b1}}) begin
            res = v[31:0];
        end else if (v[SUM_W-1]) begin
            res = 32'sh8000_0000;
        end else begin
            res = 32'sh7FFF_FFFF;
        end
        return res;
    endfunction

    // Frame memory address of one particle slot
    function automatic logic [ADDR_W-1:0] pos_addr(input logic [1:0] phase,
                                                   input logic [IDX_W-1:0] idx);
        return ADDR_W'(ADDR_W'(phase) * ADDR_W'(MAX_P) + ADDR_W'(idx));
    endfunction

endpackage

// File: hw/rtl/pgi_mul.sv
// Shared signed multiplier with operand selection and a registered product.
module pgi_mul (
    input  logic                                i_clk,
    input  pgi_pkg::t_mul_ctl                   i_ctl,
    input  logic signed [31:0]                  i_gravity,
    output logic signed [pgi_pkg::PROD_W-1:0]   o_prod
);

    logic signed [31:0]                 opa;
    logic signed [16:0]                 opb;
    logic signed [pgi_pkg::PROD_W-1:0]  r_prod;

    // Operand selection
    always_comb begin
        case (i_ctl.sel)
            pgi_pkg::MUL_TRI: begin
                opa = $signed({24'd0, i_ctl.step});
                opb = $signed(17'({9'd0, i_ctl.step}) + 17'd1);
            end
            pgi_pkg::MUL_GS: begin
                opa = i_gravity;
                opb = $signed({9'd0, i_ctl.step});
            end
            pgi_pkg::MUL_BIAS: begin
                opa = i_gravity;
                opb = $signed({1'b0, i_ctl.tri_num});
            end
            pgi_pkg::MUL_VEL: begin
                opa = i_ctl.vel;
                opb = $signed({9'd0, i_ctl.step});
            end
            default: begin
                opa = i_ctl.vel;
                opb = $signed({9'd0, i_ctl.step});
            end
        endcase
    end

    // Product register
    always_ff @(posedge i_clk) begin
        r_prod <= opa * opb;
    end

    assign o_prod = r_prod;

endmodule

// File: hw/rtl/particle_gravity_integrator.sv
// Top level: particle store, tick sequencer and result register of the integrator.
//
//  channel   handshake                  payload
//  request   i_start / o_busy           i_req  (pgi_pkg::t_req)
//  result    o_res_valid (strobe)       o_res  (pgi_pkg::t_res)
//  config    i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// Load, arm, expired ticks and ticks with no active particle are handled in the idle
// state; their result, if any, shows in the following cycle and busy stays low.
// A live tick covers N particles, N being active_count capped at 32: the accepting
// cycle, three set-up products on the shared multiplier, then per particle a store
// read, its three velocity products and the frame write.
// Synchronous active-low reset clears control state; the stores are undefined
// until loaded. Results are strobed for one cycle and cannot be held off.
module particle_gravity_integrator (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  pgi_pkg::t_req       i_req,
    output logic                o_res_valid,
    output pgi_pkg::t_res       o_res,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);

    // Configuration registers
    logic signed [31:0]  r_gravity;
    logic [5:0]          r_active;
    logic [15:0]         r_lifetime;

    // Control state
    pgi_pkg::t_state                    r_state, n_state;
    logic signed [pgi_pkg::LIFE_W-1:0]  r_life, n_life;
    logic                               r_expired, n_expired;
    logic [1:0]                         r_phase, n_phase;
    logic [1:0]                         r_oldp, n_oldp;
    logic [1:0]                         r_fill, n_fill;
    logic [1:0]                         r_cursor, n_cursor;
    logic [pgi_pkg::CNT_W-1:0]          r_cnt, n_cnt;
    logic [pgi_pkg::IDX_W-1:0]          r_idx, n_idx;
    logic                               r_res_valid, n_res_valid;

    // Datapath registers
    logic [7:0]                         r_step, n_step;
    logic [15:0]                        r_tri, n_tri;
    logic signed [pgi_pkg::PROD_W-1:0]  r_gs, n_gs;
    logic signed [pgi_pkg::PROD_W-1:0]  r_bias, n_bias;
    logic signed [pgi_pkg::SUM_W-1:0]   r_ypart, n_ypart;
    logic signed [31:0]                 r_nx, n_nx;
    logic signed [31:0]                 r_ny, n_ny;
    pgi_pkg::t_res                      r_res, n_res;

    // Stores
    logic signed [31:0] r_pos_x_mem [0:pgi_pkg::POS_DEPTH-1];
    logic signed [31:0] r_pos_y_mem [0:pgi_pkg::POS_DEPTH-1];
    logic signed [31:0] r_pos_z_mem [0:pgi_pkg::POS_DEPTH-1];
    logic signed [31:0] r_vel_x_mem [0:pgi_pkg::MAX_P-1];
    logic signed [31:0] r_vel_y_mem [0:pgi_pkg::MAX_P-1];
    logic signed [31:0] r_vel_z_mem [0:pgi_pkg::MAX_P-1];
    logic signed [31:0] r_px_rd, r_py_rd, r_pz_rd;
    logic signed [31:0] r_vx_rd, r_vy_rd, r_vz_rd;

    // Store ports
    logic                               pos_we;
    logic [pgi_pkg::ADDR_W-1:0]         pos_wa;
    logic signed [31:0]                 pos_wx, pos_wy, pos_wz;
    logic                               vel_we;
    logic                               vy_we;
    logic [pgi_pkg::IDX_W-1:0]          vel_wa;
    logic signed [31:0]                 vel_wx, vel_wy, vel_wz;
    logic                               rd_en;

    // Shared multiplier
    pgi_pkg::t_mul_ctl                  mul_ctl;
    logic signed [pgi_pkg::PROD_W-1:0]  prod;

    pgi_mul u_mul (
        .i_clk     (i_clk),
        .i_ctl     (mul_ctl),
        .i_gravity (r_gravity),
        .o_prod    (prod)
    );

    assign o_busy      = (r_state != pgi_pkg::S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;
    assign o_cfg_ready = 1'b1;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity  <= '0;
            r_active   <= '0;
            r_lifetime <= pgi_pkg::LIFETIME_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                pgi_pkg::CFG_GRAVITY:  r_gravity  <= i_cfg_data;
                pgi_pkg::CFG_ACTIVE:   r_active   <= i_cfg_data[5:0];
                pgi_pkg::CFG_LIFETIME: r_lifetime <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pgi_pkg::S_IDLE;
            r_life      <= pgi_pkg::LIFE_W'(pgi_pkg::LIFETIME_RST);
            r_expired   <= 1'b0;
            r_phase     <= '0;
            r_oldp      <= '0;
            r_fill      <= '0;
            r_cursor    <= '0;
            r_cnt       <= '0;
            r_idx       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_life      <= n_life;
            r_expired   <= n_expired;
            r_phase     <= n_phase;
            r_oldp      <= n_oldp;
            r_fill      <= n_fill;
            r_cursor    <= n_cursor;
            r_cnt       <= n_cnt;
            r_idx       <= n_idx;
            r_res_valid <= n_res_valid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_step  <= n_step;
        r_tri   <= n_tri;
        r_gs    <= n_gs;
        r_bias  <= n_bias;
        r_ypart <= n_ypart;
        r_nx    <= n_nx;
        r_ny    <= n_ny;
        r_res   <= n_res;
    end

    // Position frames: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (pos_we) begin
            r_pos_x_mem[pos_wa] <= pos_wx;
            r_pos_y_mem[pos_wa] <= pos_wy;
            r_pos_z_mem[pos_wa] <= pos_wz;
        end
        if (rd_en) begin
            r_px_rd <= r_pos_x_mem[pgi_pkg::pos_addr(r_oldp, r_idx)];
            r_py_rd <= r_pos_y_mem[pgi_pkg::pos_addr(r_oldp, r_idx)];
            r_pz_rd <= r_pos_z_mem[pgi_pkg::pos_addr(r_oldp, r_idx)];
        end
    end

    // Velocity store
    always_ff @(posedge i_clk) begin
        if (vel_we) begin
            r_vel_x_mem[vel_wa] <= vel_wx;
            r_vel_z_mem[vel_wa] <= vel_wz;
        end
        if (vy_we) begin
            r_vel_y_mem[vel_wa] <= vel_wy;
        end
        if (rd_en) begin
            r_vx_rd <= r_vel_x_mem[r_idx];
            r_vy_rd <= r_vel_y_mem[r_idx];
            r_vz_rd <= r_vel_z_mem[r_idx];
        end
    end

    // Sequencer: next state, datapath and store controls
    always_comb begin
        logic signed [pgi_pkg::LIFE_W-1:0]  life_new;
        logic [1:0]                         phase_nxt;
        logic [pgi_pkg::CNT_W-1:0]          cnt_clamp;
        logic                               last;

        n_state     = r_state;
        n_life      = r_life;
        n_expired   = r_expired;
        n_phase     = r_phase;
        n_oldp      = r_oldp;
        n_fill      = r_fill;
        n_cursor    = r_cursor;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_res_valid = 1'b0;
        n_step      = r_step;
        n_tri       = r_tri;
        n_gs        = r_gs;
        n_bias      = r_bias;
        n_ypart     = r_ypart;
        n_nx        = r_nx;
        n_ny        = r_ny;
        n_res       = r_res;

        pos_we = 1'b0;
        pos_wa = pgi_pkg::pos_addr(r_phase, r_idx);
        pos_wx = i_req.load_x;
        pos_wy = i_req.load_y;
        pos_wz = i_req.load_z;
        vel_we = 1'b0;
        vy_we  = 1'b0;
        vel_wa = r_idx;
        vel_wx = i_req.load_vx;
        vel_wy = i_req.load_vy;
        vel_wz = i_req.load_vz;
        rd_en  = 1'b0;

        mul_ctl.sel     = pgi_pkg::MUL_VEL;
        mul_ctl.vel     = r_vx_rd;
        mul_ctl.step    = r_step;
        mul_ctl.tri_num = r_tri;

        life_new  = r_life - $signed({{(pgi_pkg::LIFE_W-8){1'b0}}, i_req.step_ticks});
        phase_nxt = (r_phase == 2'(pgi_pkg::NFRAMES - 1)) ? 2'd0 : 2'(r_phase + 2'd1);
        cnt_clamp = (32'(r_active) > pgi_pkg::MAX_P) ? pgi_pkg::CNT_W'(pgi_pkg::MAX_P)
                                                      : pgi_pkg::CNT_W'(r_active);
        last      = ((pgi_pkg::CNT_W'(r_idx) + pgi_pkg::CNT_W'(1)) == r_cnt);

        case (r_state)
            pgi_pkg::S_IDLE: begin
                if (i_start) begin
                    case (i_req.opcode)
                        pgi_pkg::OP_LOAD: begin
                            if (32'(i_req.particle_index) < pgi_pkg::MAX_P) begin
                                pos_we = 1'b1;
                                pos_wa = pgi_pkg::pos_addr(r_phase,
                                             pgi_pkg::IDX_W'(i_req.particle_index));
                                vel_we = 1'b1;
                                vy_we  = 1'b1;
                                vel_wa = pgi_pkg::IDX_W'(i_req.particle_index);
                            end
                        end
                        pgi_pkg::OP_ARM: begin
                            n_life    = $signed({{(pgi_pkg::LIFE_W-16){1'b0}}, r_lifetime});
                            n_fill    = '0;
                            n_cursor  = '0;
                            n_expired = 1'b0;
                        end
                        pgi_pkg::OP_TICK: begin
                            // expired result carries the counters as they stand
                            n_res.status      = pgi_pkg::ST_EXPIRED;
                            n_res.out_index   = '0;
                            n_res.new_x       = '0;
                            n_res.new_y       = '0;
                            n_res.new_z       = '0;
                            n_res.frame_phase = r_phase;
                            n_res.bank_level  = r_fill;
                            n_res.bank_cursor = r_cursor;
                            n_res.last        = 1'b1;
                            if (r_expired) begin
                                n_res_valid = 1'b1;
                            end else begin
                                n_life = life_new;
                                if (life_new <= 0) begin
                                    n_expired   = 1'b1;
                                    n_res_valid = 1'b1;
                                end else begin
                                    // advance the frame phase and bank counters
                                    n_phase = phase_nxt;
                                    if (r_fill != 2'd3) begin
                                        n_fill = 2'(r_fill + 2'd1);
                                    end else begin
                                        n_cursor = (r_cursor == 2'd2) ? 2'd0
                                                                      : 2'(r_cursor + 2'd1);
                                    end
                                    n_res.frame_phase = n_phase;
                                    n_res.bank_level  = n_fill;
                                    n_res.bank_cursor = n_cursor;
                                    if (cnt_clamp == '0) begin
                                        n_res.status = pgi_pkg::ST_EMPTY;
                                        n_res_valid  = 1'b1;
                                    end else begin
                                        n_cnt   = cnt_clamp;
                                        n_step  = i_req.step_ticks;
                                        n_oldp  = r_phase;
                                        n_idx   = '0;
                                        n_state = pgi_pkg::S_TRI;
                                    end
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            // s * (s + 1)
            pgi_pkg::S_TRI: begin
                mul_ctl.sel = pgi_pkg::MUL_TRI;
                n_state     = pgi_pkg::S_GS;
            end
            // gravity * s; halve the triangle product
            pgi_pkg::S_GS: begin
                mul_ctl.sel = pgi_pkg::MUL_GS;
                n_tri       = prod[16:1];
                n_state     = pgi_pkg::S_BIAS;
            end
            // gravity * s(s+1)/2; keep the velocity change
            pgi_pkg::S_BIAS: begin
                mul_ctl.sel = pgi_pkg::MUL_BIAS;
                n_gs        = -prod;
                n_state     = pgi_pkg::S_RD;
            end
            // read the particle's old position and velocity
            pgi_pkg::S_RD: begin
                if (r_idx == '0) begin
                    n_bias = -prod;
                end
                rd_en   = 1'b1;
                n_state = pgi_pkg::S_MX;
            end
            // vx * s; start the y sum with the gravity bias
            pgi_pkg::S_MX: begin
                mul_ctl.sel = pgi_pkg::MUL_VEL;
                mul_ctl.vel = r_vx_rd;
                n_ypart     = pgi_pkg::SUM_W'(r_py_rd) + pgi_pkg::SUM_W'(r_bias);
                n_state     = pgi_pkg::S_MY;
            end
            // vy * s; finish x
            pgi_pkg::S_MY: begin
                mul_ctl.sel = pgi_pkg::MUL_VEL;
                mul_ctl.vel = r_vy_rd;
                n_nx        = pgi_pkg::sat32(pgi_pkg::SUM_W'(r_px_rd)
                                             + pgi_pkg::SUM_W'(prod));
                n_state     = pgi_pkg::S_MZ;
            end
            // vz * s; finish y and update vy
            pgi_pkg::S_MZ: begin
                mul_ctl.sel = pgi_pkg::MUL_VEL;
                mul_ctl.vel = r_vz_rd;
                n_ny        = pgi_pkg::sat32(r_ypart + pgi_pkg::SUM_W'(prod));
                vy_we       = 1'b1;
                vel_wa      = r_idx;
                vel_wy      = pgi_pkg::sat32(pgi_pkg::SUM_W'(r_vy_rd)
                                             + pgi_pkg::SUM_W'(r_gs));
                n_state     = pgi_pkg::S_WR;
            end
            // finish z, write the new frame and emit the result
            pgi_pkg::S_WR: begin
                pos_we = 1'b1;
                pos_wa = pgi_pkg::pos_addr(r_phase, r_idx);
                pos_wx = r_nx;
                pos_wy = r_ny;
                pos_wz = pgi_pkg::sat32(pgi_pkg::SUM_W'(r_pz_rd) + pgi_pkg::SUM_W'(prod));
                n_res.status      = pgi_pkg::ST_POS;
                n_res.out_index   = 5'(r_idx);
                n_res.new_x       = r_nx;
                n_res.new_y       = r_ny;
                n_res.new_z       = pos_wz;
                n_res.frame_phase = r_phase;
                n_res.bank_level  = r_fill;
                n_res.bank_cursor = r_cursor;
                n_res.last        = last;
                n_res_valid       = 1'b1;
                if (last) begin
                    n_state = pgi_pkg::S_IDLE;
                end else begin
                    n_idx   = pgi_pkg::IDX_W'(r_idx + 1'b1);
                    n_state = pgi_pkg::S_RD;
                end
            end
            default: begin
                n_state = pgi_pkg::S_IDLE;
            end
        endcase
    end

endmodule
